@@ rtl/core/nnra_pkg.sv @@
// ----------------------------------------------------------------------------
// nnra_pkg
// Shared widths, register codes, derived-config type and helpers for the
// nearest-neighbor resize address generator.
// ----------------------------------------------------------------------------
package nnra_pkg;

    localparam int MAX_DIM  = 4096;
    localparam int INDEX_W  = 40;
    localparam int FRAC_W   = 16;

    localparam int COORD_W  = $clog2(MAX_DIM);
    localparam int DIM_W    = COORD_W + 1;
    localparam int RATIO_W  = 32;
    localparam int AREA_W   = 2 * COORD_W + 1;
    localparam int PROD_W   = COORD_W + RATIO_W;
    localparam int SC_W     = PROD_W + 1 - FRAC_W;
    localparam int LO_W     = INDEX_W / 2;
    localparam int HI_W     = INDEX_W - LO_W;
    localparam int PLO_W    = LO_W + AREA_W;
    localparam int PHI_W    = HI_W + AREA_W;
    localparam int ROWOFF_W = COORD_W + DIM_W;

    localparam int IN_TDATA_W   = ((INDEX_W + 7) / 8) * 8;
    localparam int OUT_FIELDS_W = 2 * INDEX_W + 2 * COORD_W;
    localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;
    localparam int APB_ADDR_W = REG_IDX_W + 2;

    localparam logic [RATIO_W-1:0] RATIO_ONE = RATIO_W'(64'd1 << FRAC_W);
    localparam logic [PROD_W:0]    ROUND_HALF = (PROD_W + 1)'(64'd1 << (FRAC_W - 1));

    typedef enum logic [REG_IDX_W-1:0] {
        REG_IN_ROWS      = 3'd0,
        REG_IN_COLS      = 3'd1,
        REG_OUT_ROWS     = 3'd2,
        REG_OUT_COLS     = 3'd3,
        REG_CORNER_ALIGN = 3'd4,
        REG_ROW_RATIO    = 3'd5,
        REG_COL_RATIO    = 3'd6
    } nnra_reg_t;

    typedef struct packed {
        logic [DIM_W-1:0]   out_rows;
        logic [DIM_W-1:0]   out_cols;
        logic [DIM_W-1:0]   in_cols;
        logic [COORD_W-1:0] row_max;
        logic [COORD_W-1:0] col_max;
        logic [AREA_W-1:0]  area;
        logic               corner_align;
        logic [RATIO_W-1:0] row_ratio;
        logic [RATIO_W-1:0] col_ratio;
    } nnra_cfg_t;

    localparam nnra_cfg_t CFG_RESET = '{
        out_rows:     DIM_W'(1),
        out_cols:     DIM_W'(1),
        in_cols:      DIM_W'(1),
        row_max:      '0,
        col_max:      '0,
        area:         AREA_W'(1),
        corner_align: 1'b0,
        row_ratio:    RATIO_ONE,
        col_ratio:    RATIO_ONE
    };

    // Zero counts as one, anything above the maximum counts as the maximum.
    function automatic logic [DIM_W-1:0] eff_dim(input logic [DIM_W-1:0] v);
        logic [DIM_W-1:0] r;
        if (v == '0)
            r = DIM_W'(1);
        else if (v > DIM_W'(MAX_DIM))
            r = DIM_W'(MAX_DIM);
        else
            r = v;
        return r;
    endfunction

endpackage

@@ rtl/core/nnra_divider.sv @@
// ----------------------------------------------------------------------------
// nnra_divider
// Pipelined restoring divider: one quotient bit per stage, with a sideband
// that travels alongside each item.
// ----------------------------------------------------------------------------
module nnra_divider (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  logic                          in_valid,
    input  logic [nnra_pkg::INDEX_W-1:0]  in_num,
    input  logic [nnra_pkg::COORD_W-1:0]  in_side,
    input  logic [nnra_pkg::DIM_W-1:0]    divisor,
    output logic                          out_valid,
    output logic [nnra_pkg::INDEX_W-1:0]  out_quo,
    output logic [nnra_pkg::COORD_W-1:0]  out_rem,
    output logic [nnra_pkg::COORD_W-1:0]  out_side
);

    logic                         valid_reg [0:nnra_pkg::INDEX_W];
    logic [nnra_pkg::INDEX_W-1:0] num_reg   [0:nnra_pkg::INDEX_W];
    logic [nnra_pkg::COORD_W-1:0] rem_reg   [0:nnra_pkg::INDEX_W];
    logic [nnra_pkg::COORD_W-1:0] side_reg  [0:nnra_pkg::INDEX_W];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg[0] <= 1'b0;
        end
        else if (en)
        begin
            valid_reg[0] <= in_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            num_reg[0]  <= in_num;
            rem_reg[0]  <= '0;
            side_reg[0] <= in_side;
        end
    end

    // num_reg shifts the dividend out at the top and the quotient in at the bottom
    for (genvar k = 0; k < nnra_pkg::INDEX_W; k++)
    begin : gen_step
        logic [nnra_pkg::DIM_W-1:0]   trial;
        logic                         fits;
        logic [nnra_pkg::COORD_W-1:0] rem_next;
        logic [nnra_pkg::INDEX_W-1:0] num_next;

        always_comb
        begin
            trial    = {rem_reg[k], num_reg[k][nnra_pkg::INDEX_W-1]};
            fits     = (trial >= divisor);
            rem_next = fits ? nnra_pkg::COORD_W'(trial - divisor)
                            : trial[nnra_pkg::COORD_W-1:0];
            num_next = {num_reg[k][nnra_pkg::INDEX_W-2:0], fits};
        end

        always_ff @(posedge clk or negedge rst_n)
        begin
            if (!rst_n)
            begin
                valid_reg[k+1] <= 1'b0;
            end
            else if (en)
            begin
                valid_reg[k+1] <= valid_reg[k];
            end
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                num_reg[k+1]  <= num_next;
                rem_reg[k+1]  <= rem_next;
                side_reg[k+1] <= side_reg[k];
            end
        end
    end

    assign out_valid = valid_reg[nnra_pkg::INDEX_W];
    assign out_quo   = num_reg[nnra_pkg::INDEX_W];
    assign out_rem   = rem_reg[nnra_pkg::INDEX_W];
    assign out_side  = side_reg[nnra_pkg::INDEX_W];

endmodule

@@ rtl/core/nnra_map.sv @@
// ----------------------------------------------------------------------------
// nnra_map
// Scales output row and column to source coordinates, clamps them and forms
// the linear source index over four register stages.
// ----------------------------------------------------------------------------
module nnra_map (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          en,
    input  nnra_pkg::nnra_cfg_t           cfg,
    input  logic                          in_valid,
    input  logic [nnra_pkg::INDEX_W-1:0]  in_plane,
    input  logic [nnra_pkg::COORD_W-1:0]  in_row,
    input  logic [nnra_pkg::COORD_W-1:0]  in_col,
    output logic                          out_valid,
    output logic [nnra_pkg::INDEX_W-1:0]  out_src,
    output logic [nnra_pkg::INDEX_W-1:0]  out_plane,
    output logic [nnra_pkg::COORD_W-1:0]  out_row,
    output logic [nnra_pkg::COORD_W-1:0]  out_col
);

    // Stage A: products
    logic                          a_valid_reg;
    logic [nnra_pkg::PROD_W-1:0]   a_prow_reg, a_prow_next;
    logic [nnra_pkg::PROD_W-1:0]   a_pcol_reg, a_pcol_next;
    logic [nnra_pkg::PLO_W-1:0]    a_plo_reg, a_plo_next;
    logic [nnra_pkg::HI_W-1:0]     a_phi_reg, a_phi_next;
    logic [nnra_pkg::PHI_W-1:0]    phi_full;
    logic [nnra_pkg::INDEX_W-1:0]  a_plane_reg;

    // Stage B: rounded, clamped coordinates and plane base
    logic                          b_valid_reg;
    logic [nnra_pkg::COORD_W-1:0]  b_row_reg, b_row_next;
    logic [nnra_pkg::COORD_W-1:0]  b_col_reg, b_col_next;
    logic [nnra_pkg::INDEX_W-1:0]  b_base_reg, b_base_next;
    logic [nnra_pkg::INDEX_W-1:0]  b_plane_reg;
    logic [nnra_pkg::PROD_W:0]     half;
    logic [nnra_pkg::PROD_W:0]     rrow_sum, rcol_sum;
    logic [nnra_pkg::SC_W-1:0]     srow, scol;

    // Stage C: row offset
    logic                          c_valid_reg;
    logic [nnra_pkg::ROWOFF_W-1:0] c_rowoff_reg, c_rowoff_next;
    logic [nnra_pkg::COORD_W-1:0]  c_row_reg, c_col_reg;
    logic [nnra_pkg::INDEX_W-1:0]  c_base_reg, c_plane_reg;

    // Stage D: output
    logic                          d_valid_reg;
    logic [nnra_pkg::INDEX_W-1:0]  d_src_reg, d_src_next;
    logic [nnra_pkg::INDEX_W-1:0]  d_plane_reg;
    logic [nnra_pkg::COORD_W-1:0]  d_row_reg, d_col_reg;

    always_comb
    begin
        a_prow_next = nnra_pkg::PROD_W'(in_row) * nnra_pkg::PROD_W'(cfg.row_ratio);
        a_pcol_next = nnra_pkg::PROD_W'(in_col) * nnra_pkg::PROD_W'(cfg.col_ratio);
        a_plo_next  = nnra_pkg::PLO_W'(in_plane[nnra_pkg::LO_W-1:0])
                    * nnra_pkg::PLO_W'(cfg.area);
        phi_full    = nnra_pkg::PHI_W'(in_plane[nnra_pkg::INDEX_W-1:nnra_pkg::LO_W])
                    * nnra_pkg::PHI_W'(cfg.area);
        a_phi_next  = phi_full[nnra_pkg::HI_W-1:0];
    end

    always_comb
    begin
        half       = cfg.corner_align ? nnra_pkg::ROUND_HALF : '0;
        rrow_sum   = {1'b0, a_prow_reg} + half;
        rcol_sum   = {1'b0, a_pcol_reg} + half;
        srow       = rrow_sum[nnra_pkg::PROD_W:nnra_pkg::FRAC_W];
        scol       = rcol_sum[nnra_pkg::PROD_W:nnra_pkg::FRAC_W];
        b_row_next = (srow < nnra_pkg::SC_W'(cfg.row_max))
                   ? srow[nnra_pkg::COORD_W-1:0] : cfg.row_max;
        b_col_next = (scol < nnra_pkg::SC_W'(cfg.col_max))
                   ? scol[nnra_pkg::COORD_W-1:0] : cfg.col_max;
        b_base_next = nnra_pkg::INDEX_W'(a_plo_reg) + {a_phi_reg, {nnra_pkg::LO_W{1'b0}}};
    end

    always_comb
    begin
        c_rowoff_next = nnra_pkg::ROWOFF_W'(b_row_reg) * nnra_pkg::ROWOFF_W'(cfg.in_cols);
        d_src_next    = c_base_reg + nnra_pkg::INDEX_W'(c_rowoff_reg)
                      + nnra_pkg::INDEX_W'(c_col_reg);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            a_valid_reg <= 1'b0;
            b_valid_reg <= 1'b0;
            c_valid_reg <= 1'b0;
            d_valid_reg <= 1'b0;
        end
        else if (en)
        begin
            a_valid_reg <= in_valid;
            b_valid_reg <= a_valid_reg;
            c_valid_reg <= b_valid_reg;
            d_valid_reg <= c_valid_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            a_prow_reg   <= a_prow_next;
            a_pcol_reg   <= a_pcol_next;
            a_plo_reg    <= a_plo_next;
            a_phi_reg    <= a_phi_next;
            a_plane_reg  <= in_plane;

            b_row_reg    <= b_row_next;
            b_col_reg    <= b_col_next;
            b_base_reg   <= b_base_next;
            b_plane_reg  <= a_plane_reg;

            c_rowoff_reg <= c_rowoff_next;
            c_row_reg    <= b_row_reg;
            c_col_reg    <= b_col_reg;
            c_base_reg   <= b_base_reg;
            c_plane_reg  <= b_plane_reg;

            d_src_reg    <= d_src_next;
            d_plane_reg  <= c_plane_reg;
            d_row_reg    <= c_row_reg;
            d_col_reg    <= c_col_reg;
        end
    end

    assign out_valid = d_valid_reg;
    assign out_src   = d_src_reg;
    assign out_plane = d_plane_reg;
    assign out_row   = d_row_reg;
    assign out_col   = d_col_reg;

endmodule

@@ rtl/core/nearest_neighbor_resize_address.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_resize_address
// Gather-address generator for nearest-neighbor image resize.
//
// Each item on the s_ channel is a linear output element index (plane, then
// row, then column). For each one the m_ channel returns one item: the source
// element index, the plane number and the clamped source row and column.
// Sizes, the rounding mode and the Q16.16 row/column ratios sit in APB
// registers; change them only while no item is in flight.
// Throughput is one item per cycle while the output is not stalled. Each item
// passes two 41-stage dividers (one quotient
// bit per stage, first by the output width, then by the output height) and
// four stages of multiply, round/clamp and index add.
// When m_tvalid is high and m_tready low the whole pipeline holds; one skid register still takes
// an item, and s_tready drops only while that register is full.
// Reset empties the pipeline and loads sizes of 1, flooring and ratios of 1.0.
// ----------------------------------------------------------------------------
module nearest_neighbor_resize_address (
    input  logic                              clk,
    input  logic                              rst_n,
    // APB configuration
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [nnra_pkg::APB_ADDR_W-1:0]   paddr,
    input  logic [nnra_pkg::APB_DATA_W-1:0]   pwdata,
    output logic [nnra_pkg::APB_DATA_W-1:0]   prdata,
    output logic                              pready,
    // input items
    input  logic                              s_tvalid,
    output logic                              s_tready,
    input  logic [nnra_pkg::IN_TDATA_W-1:0]   s_tdata,   // out_index
    // result items
    output logic                              m_tvalid,
    input  logic                              m_tready,
    output logic [nnra_pkg::OUT_TDATA_W-1:0]  m_tdata    // src_index, plane_index,
                                                         // src_row, src_col
);

    logic [nnra_pkg::DIM_W-1:0]   in_rows_reg, in_cols_reg;
    logic [nnra_pkg::DIM_W-1:0]   out_rows_reg, out_cols_reg;
    logic                         corner_align_reg;
    logic [nnra_pkg::RATIO_W-1:0] row_ratio_reg, col_ratio_reg;
    logic                         cfg_write;
    logic [nnra_pkg::REG_IDX_W-1:0] reg_idx;

    nnra_pkg::nnra_cfg_t          cfg_reg, cfg_next;
    logic [nnra_pkg::DIM_W-1:0]   eff_in_rows, eff_in_cols;

    logic                         skid_valid_reg, skid_valid_next;
    logic [nnra_pkg::INDEX_W-1:0] skid_data_reg, skid_data_next;
    logic                         pipe_en;
    logic                         feed_valid;
    logic [nnra_pkg::INDEX_W-1:0] feed_data;

    logic                         d1_valid;
    logic [nnra_pkg::INDEX_W-1:0] d1_quo;
    logic [nnra_pkg::COORD_W-1:0] d1_rem, d1_side;
    logic                         d2_valid;
    logic [nnra_pkg::INDEX_W-1:0] d2_quo;
    logic [nnra_pkg::COORD_W-1:0] d2_rem, d2_side;

    logic [nnra_pkg::INDEX_W-1:0] res_src, res_plane;
    logic [nnra_pkg::COORD_W-1:0] res_row, res_col;

    // ---------------- configuration port ----------------
    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign reg_idx   = paddr[nnra_pkg::APB_ADDR_W-1:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_rows_reg      <= nnra_pkg::DIM_W'(1);
            in_cols_reg      <= nnra_pkg::DIM_W'(1);
            out_rows_reg     <= nnra_pkg::DIM_W'(1);
            out_cols_reg     <= nnra_pkg::DIM_W'(1);
            corner_align_reg <= 1'b0;
            row_ratio_reg    <= nnra_pkg::RATIO_ONE;
            col_ratio_reg    <= nnra_pkg::RATIO_ONE;
        end
        else if (cfg_write)
        begin
            case (reg_idx)
                nnra_pkg::REG_IN_ROWS:      in_rows_reg      <= pwdata[nnra_pkg::DIM_W-1:0];
                nnra_pkg::REG_IN_COLS:      in_cols_reg      <= pwdata[nnra_pkg::DIM_W-1:0];
                nnra_pkg::REG_OUT_ROWS:     out_rows_reg     <= pwdata[nnra_pkg::DIM_W-1:0];
                nnra_pkg::REG_OUT_COLS:     out_cols_reg     <= pwdata[nnra_pkg::DIM_W-1:0];
                nnra_pkg::REG_CORNER_ALIGN: corner_align_reg <= pwdata[0];
                nnra_pkg::REG_ROW_RATIO:    row_ratio_reg    <= pwdata[nnra_pkg::RATIO_W-1:0];
                nnra_pkg::REG_COL_RATIO:    col_ratio_reg    <= pwdata[nnra_pkg::RATIO_W-1:0];
                default:                    ;
            endcase
        end
    end

    always_comb
    begin
        case (reg_idx)
            nnra_pkg::REG_IN_ROWS:      prdata = nnra_pkg::APB_DATA_W'(in_rows_reg);
            nnra_pkg::REG_IN_COLS:      prdata = nnra_pkg::APB_DATA_W'(in_cols_reg);
            nnra_pkg::REG_OUT_ROWS:     prdata = nnra_pkg::APB_DATA_W'(out_rows_reg);
            nnra_pkg::REG_OUT_COLS:     prdata = nnra_pkg::APB_DATA_W'(out_cols_reg);
            nnra_pkg::REG_CORNER_ALIGN: prdata = nnra_pkg::APB_DATA_W'(corner_align_reg);
            nnra_pkg::REG_ROW_RATIO:    prdata = nnra_pkg::APB_DATA_W'(row_ratio_reg);
            nnra_pkg::REG_COL_RATIO:    prdata = nnra_pkg::APB_DATA_W'(col_ratio_reg);
            default:                    prdata = '0;
        endcase
    end

    // Effective sizes, clamp bounds and plane area, registered once
    always_comb
    begin
        eff_in_rows           = nnra_pkg::eff_dim(in_rows_reg);
        eff_in_cols           = nnra_pkg::eff_dim(in_cols_reg);
        cfg_next.out_rows     = nnra_pkg::eff_dim(out_rows_reg);
        cfg_next.out_cols     = nnra_pkg::eff_dim(out_cols_reg);
        cfg_next.in_cols      = eff_in_cols;
        cfg_next.row_max      = nnra_pkg::COORD_W'(eff_in_rows - nnra_pkg::DIM_W'(1));
        cfg_next.col_max      = nnra_pkg::COORD_W'(eff_in_cols - nnra_pkg::DIM_W'(1));
        cfg_next.area         = nnra_pkg::AREA_W'(eff_in_rows) * nnra_pkg::AREA_W'(eff_in_cols);
        cfg_next.corner_align = corner_align_reg;
        cfg_next.row_ratio    = row_ratio_reg;
        cfg_next.col_ratio    = col_ratio_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= nnra_pkg::CFG_RESET;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    // ---------------- input skid and pipeline enable ----------------
    assign pipe_en    = !m_tvalid || m_tready;
    assign s_tready   = !skid_valid_reg;
    assign feed_valid = skid_valid_reg || s_tvalid;
    assign feed_data  = skid_valid_reg ? skid_data_reg : s_tdata[nnra_pkg::INDEX_W-1:0];

    always_comb
    begin
        skid_valid_next = skid_valid_reg;
        skid_data_next  = skid_data_reg;
        if (pipe_en)
        begin
            skid_valid_next = 1'b0;
        end
        else if (s_tvalid && s_tready)
        begin
            // park the item while the pipeline holds
            skid_valid_next = 1'b1;
            skid_data_next  = s_tdata[nnra_pkg::INDEX_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            skid_valid_reg <= skid_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        skid_data_reg <= skid_data_next;
    end

    // ---------------- datapath ----------------
    // index / out_cols -> global row, column
    nnra_divider u_div_col (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (feed_valid),
        .in_num    (feed_data),
        .in_side   ('0),
        .divisor   (cfg_reg.out_cols),
        .out_valid (d1_valid),
        .out_quo   (d1_quo),
        .out_rem   (d1_rem),
        .out_side  (d1_side)
    );

    // global row / out_rows -> plane, row; column rides along
    nnra_divider u_div_row (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .in_valid  (d1_valid),
        .in_num    (d1_quo),
        .in_side   (d1_rem),
        .divisor   (cfg_reg.out_rows),
        .out_valid (d2_valid),
        .out_quo   (d2_quo),
        .out_rem   (d2_rem),
        .out_side  (d2_side)
    );

    nnra_map u_map (
        .clk       (clk),
        .rst_n     (rst_n),
        .en        (pipe_en),
        .cfg       (cfg_reg),
        .in_valid  (d2_valid),
        .in_plane  (d2_quo),
        .in_row    (d2_rem),
        .in_col    (d2_side),
        .out_valid (m_tvalid),
        .out_src   (res_src),
        .out_plane (res_plane),
        .out_row   (res_row),
        .out_col   (res_col)
    );

    assign m_tdata = nnra_pkg::OUT_TDATA_W'({res_col, res_row, res_plane, res_src});

endmodule

@@ sim/nearest_neighbor_resize_address_tb.sv @@
// ----------------------------------------------------------------------------
// nearest_neighbor_resize_address_tb
// Self-checking bench for the nearest-neighbor resize address generator.
// Loads size, rounding and ratio registers over APB, streams output element
// indices and checks every returned gather address against a listed value or
// a local model of the plane/row/column split, fixed-point scaling and clamping.
// Source gaps and sink stalls come in random bursts, except in the last phase.
// ----------------------------------------------------------------------------
module nearest_neighbor_resize_address_tb;

    localparam int          PHASES         = 10;
    localparam int          PHASE_ITEMS    = 85;
    localparam int          WATCHDOG_LIMIT = 2000;
    localparam logic [2:0]  UNUSED_REG     = 3'd7;

    typedef struct packed {
        logic [nnra_pkg::COORD_W-1:0] src_col;
        logic [nnra_pkg::COORD_W-1:0] src_row;
        logic [nnra_pkg::INDEX_W-1:0] plane_index;
        logic [nnra_pkg::INDEX_W-1:0] src_index;
    } gather_t;

    typedef struct {
        bit                           is_write;
        logic [2:0]                   reg_idx;
        logic [31:0]                  wdata;
        logic [nnra_pkg::INDEX_W-1:0] index;
        bit                           typed;
        gather_t                      want;
    } plan_row_t;

    logic                             clk;
    logic                             rst_n;
    logic                             psel;
    logic                             penable;
    logic                             pwrite;
    logic [nnra_pkg::APB_ADDR_W-1:0]  paddr;
    logic [nnra_pkg::APB_DATA_W-1:0]  pwdata;
    logic [nnra_pkg::APB_DATA_W-1:0]  prdata;
    logic                             pready;
    logic                             s_tvalid;
    logic                             s_tready;
    logic [nnra_pkg::IN_TDATA_W-1:0]  s_tdata;   // out_index
    logic                             m_tvalid;
    logic                             m_tready;
    logic [nnra_pkg::OUT_TDATA_W-1:0] m_tdata;   // src_index, plane_index, src_row, src_col

    // register shadows
    logic [12:0] rows_in_cfg;
    logic [12:0] cols_in_cfg;
    logic [12:0] rows_out_cfg;
    logic [12:0] cols_out_cfg;
    logic        align_cfg;
    logic [31:0] row_step_cfg;
    logic [31:0] col_step_cfg;

    gather_t   pending_gathers[$];
    plan_row_t plan[$];
    int        mismatch_count;
    bit        quiet;

    nearest_neighbor_resize_address uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .psel     (psel),
        .penable  (penable),
        .pwrite   (pwrite),
        .paddr    (paddr),
        .pwdata   (pwdata),
        .prdata   (prdata),
        .pready   (pready),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    always #5 clk = ~clk;

    function automatic logic [63:0] size_used(input logic [12:0] v);
        if (v == 13'd0)
            return 64'd1;
        if (v > 13'd4096)
            return 64'd4096;
        return 64'(v);
    endfunction

    function automatic logic [63:0] scaled_coord(input logic [63:0] coord,
                                                 input logic [31:0] ratio,
                                                 input logic [63:0] lim);
        logic [63:0] p;
        logic [63:0] s;
        p = coord * 64'(ratio);
        if (align_cfg)
            p = p + (64'd1 << (nnra_pkg::FRAC_W - 1));
        s = p >> nnra_pkg::FRAC_W;
        return (s < lim - 1) ? s : lim - 1;
    endfunction

    function automatic gather_t predict_gather(input logic [nnra_pkg::INDEX_W-1:0] idx);
        logic [63:0] ih, iw, oh, ow, plane, rem, sy, sx, src;
        gather_t     g;
        ih    = size_used(rows_in_cfg);
        iw    = size_used(cols_in_cfg);
        oh    = size_used(rows_out_cfg);
        ow    = size_used(cols_out_cfg);
        plane = 64'(idx) / (oh * ow);
        rem   = 64'(idx) % (oh * ow);
        sy    = scaled_coord(rem / ow, row_step_cfg, ih);
        sx    = scaled_coord(rem % ow, col_step_cfg, iw);
        src   = plane * (ih * iw) + sy * iw + sx;
        g.src_index   = src[nnra_pkg::INDEX_W-1:0];
        g.plane_index = plane[nnra_pkg::INDEX_W-1:0];
        g.src_row     = sy[nnra_pkg::COORD_W-1:0];
        g.src_col     = sx[nnra_pkg::COORD_W-1:0];
        return g;
    endfunction

    function automatic gather_t make_gather(input logic [nnra_pkg::INDEX_W-1:0] src,
                                            input logic [nnra_pkg::INDEX_W-1:0] plane,
                                            input logic [nnra_pkg::COORD_W-1:0] row,
                                            input logic [nnra_pkg::COORD_W-1:0] col);
        gather_t g;
        g.src_index   = src;
        g.plane_index = plane;
        g.src_row     = row;
        g.src_col     = col;
        return g;
    endfunction

    function automatic void apply_register(input logic [2:0] idx, input logic [31:0] data);
        case (idx)
            nnra_pkg::REG_IN_ROWS:      rows_in_cfg  = data[12:0];
            nnra_pkg::REG_IN_COLS:      cols_in_cfg  = data[12:0];
            nnra_pkg::REG_OUT_ROWS:     rows_out_cfg = data[12:0];
            nnra_pkg::REG_OUT_COLS:     cols_out_cfg = data[12:0];
            nnra_pkg::REG_CORNER_ALIGN: align_cfg    = data[0];
            nnra_pkg::REG_ROW_RATIO:    row_step_cfg = data;
            nnra_pkg::REG_COL_RATIO:    col_step_cfg = data;
            default: ;
        endcase
    endfunction

    function automatic void plan_write(input logic [2:0] idx, input logic [31:0] data);
        plan_row_t r;
        r          = '{default: '0};
        r.is_write = 1'b1;
        r.reg_idx  = idx;
        r.wdata    = data;
        plan.push_back(r);
    endfunction

    function automatic void plan_item(input logic [nnra_pkg::INDEX_W-1:0] idx);
        plan_row_t r;
        r       = '{default: '0};
        r.index = idx;
        plan.push_back(r);
    endfunction

    function automatic void plan_typed(input logic [nnra_pkg::INDEX_W-1:0] idx,
                                       input gather_t g);
        plan_row_t r;
        r       = '{default: '0};
        r.index = idx;
        r.typed = 1'b1;
        r.want  = g;
        plan.push_back(r);
    endfunction

    function automatic logic [12:0] pick_size();
        case ($urandom_range(0, 9))
            0:       return 13'd0;
            1:       return 13'($urandom_range(4097, 8191));
            2:       return 13'($urandom_range(1, 4096));
            default: return 13'($urandom_range(1, 12));
        endcase
    endfunction

    function automatic logic [31:0] pick_ratio(input logic [12:0] src_size,
                                               input logic [12:0] dst_size);
        logic [63:0] base;
        case ($urandom_range(0, 7))
            0:       return $urandom;
            1:       return 32'd0;
            2:       return 32'hFFFF_FFFF;
            default:
            begin
                base = (size_used(src_size) << nnra_pkg::FRAC_W) / size_used(dst_size);
                return 32'(base + 64'($urandom_range(0, 511)));
            end
        endcase
    endfunction

    function automatic logic [nnra_pkg::INDEX_W-1:0] pick_index();
        logic [63:0] area;
        logic [63:0] v;
        area = size_used(rows_out_cfg) * size_used(cols_out_cfg);
        case ($urandom_range(0, 7))
            0, 1:    v = {24'd0, 8'($urandom_range(0, 255)), 32'($urandom)};
            2:       v = 64'($urandom_range(0, 63)) * area + 64'($urandom) % area;
            default: v = 64'($urandom_range(0, 7)) * area + 64'($urandom) % area;
        endcase
        return v[nnra_pkg::INDEX_W-1:0];
    endfunction

    // Call at a falling edge; returns at the falling edge after the write.
    task automatic write_register(input logic [2:0] idx, input logic [31:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= data;
        @(negedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        apply_register(idx, data);
        @(negedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    // Leaves s_tvalid high; the caller lowers it for a gap.
    task automatic send_item(input logic [nnra_pkg::INDEX_W-1:0] idx, input bit typed,
                             input gather_t want);
        s_tdata  <= idx;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pending_gathers.push_back(typed ? want : predict_gather(idx));
        @(negedge clk);
    endtask

    task automatic item_gap();
        if (!quiet && $urandom_range(0, 5) == 0)
        begin
            s_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(negedge clk);
        end
    endtask

    task automatic drain();
        while (pending_gathers.size() != 0)
            @(negedge clk);
        repeat (2) @(negedge clk);
    endtask

    task automatic randomize_registers();
        logic [31:0] word;
        word = $urandom; word[12:0] = pick_size(); write_register(nnra_pkg::REG_IN_ROWS, word);
        word = $urandom; word[12:0] = pick_size(); write_register(nnra_pkg::REG_IN_COLS, word);
        word = $urandom; word[12:0] = pick_size(); write_register(nnra_pkg::REG_OUT_ROWS, word);
        word = $urandom; word[12:0] = pick_size(); write_register(nnra_pkg::REG_OUT_COLS, word);
        write_register(nnra_pkg::REG_CORNER_ALIGN, $urandom);
        write_register(nnra_pkg::REG_ROW_RATIO, pick_ratio(rows_in_cfg, rows_out_cfg));
        write_register(nnra_pkg::REG_COL_RATIO, pick_ratio(cols_in_cfg, cols_out_cfg));
        if ($urandom_range(0, 3) == 0)
            write_register(UNUSED_REG, $urandom);
    endtask

    always @(posedge clk)
    begin : result_check
        gather_t got;
        gather_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            got = gather_t'(m_tdata[$bits(gather_t)-1:0]);
            if (pending_gathers.size() == 0)
            begin
                $error("unexpected result item, src_index %0h", got.src_index);
                mismatch_count++;
            end
            else
            begin
                want = pending_gathers.pop_front();
                if (got.src_index !== want.src_index)
                begin
                    $error("src_index: expected %0h, got %0h", want.src_index, got.src_index);
                    mismatch_count++;
                end
                if (got.plane_index !== want.plane_index)
                begin
                    $error("plane_index: expected %0h, got %0h",
                           want.plane_index, got.plane_index);
                    mismatch_count++;
                end
                if (got.src_row !== want.src_row)
                begin
                    $error("src_row: expected %0d, got %0d", want.src_row, got.src_row);
                    mismatch_count++;
                end
                if (got.src_col !== want.src_col)
                begin
                    $error("src_col: expected %0d, got %0d", want.src_col, got.src_col);
                    mismatch_count++;
                end
            end
        end
    end

    // Sink stalls in bursts, none in the quiet phase.
    initial
    begin
        wait (rst_n === 1'b1);
        @(negedge clk);
        forever
        begin
            if (!quiet && $urandom_range(0, 2) == 0)
            begin
                m_tready <= 1'b0;
                repeat ($urandom_range(1, 11)) @(negedge clk);
            end
            else
            begin
                m_tready <= 1'b1;
                repeat ($urandom_range(1, 24)) @(negedge clk);
            end
        end
    end

    initial
    begin : watchdog
        int unsigned idle_count;
        idle_count = 0;
        while (idle_count < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (psel && penable))
                idle_count = 0;
            else
                idle_count++;
        end
        $display("[nearest_neighbor_resize_address] ERROR");
        $finish;
    end

    initial
    begin : stimulus
        int n;
        clk            = 1'b0;
        rst_n          = 1'b0;
        psel           = 1'b0;
        penable        = 1'b0;
        pwrite         = 1'b0;
        paddr          = '0;
        pwdata         = '0;
        s_tvalid       = 1'b0;
        s_tdata        = '0;
        m_tready       = 1'b0;
        mismatch_count = 0;
        quiet          = 1'b0;
        rows_in_cfg    = 13'd1;
        cols_in_cfg    = 13'd1;
        rows_out_cfg   = 13'd1;
        cols_out_cfg   = 13'd1;
        align_cfg      = 1'b0;
        row_step_cfg   = nnra_pkg::RATIO_ONE;
        col_step_cfg   = nnra_pkg::RATIO_ONE;

        // all sizes 1 after reset: every index is its own plane
        plan_typed(40'h00_0000_0000, make_gather(40'h0, 40'h0, 12'd0, 12'd0));
        plan_typed(40'hFF_FFFF_FFFF,
                   make_gather(40'hFF_FFFF_FFFF, 40'hFF_FFFF_FFFF, 12'd0, 12'd0));
        plan_typed(40'hA5_5A5A_A5A5,
                   make_gather(40'hA5_5A5A_A5A5, 40'hA5_5A5A_A5A5, 12'd0, 12'd0));
        // largest planes, zero and oversize sizes, saturating column ratio
        plan_write(nnra_pkg::REG_IN_ROWS,   32'hFFFF_F000);
        plan_write(nnra_pkg::REG_IN_COLS,   32'h0000_1FFF);
        plan_write(nnra_pkg::REG_OUT_ROWS,  32'hFFFF_E000);
        plan_write(nnra_pkg::REG_OUT_COLS,  32'h0000_1000);
        plan_write(nnra_pkg::REG_COL_RATIO, 32'hFFFF_FFFF);
        plan_typed(40'd0, make_gather(40'd0, 40'd0, 12'd0, 12'd0));
        plan_typed(40'd1, make_gather(40'd4095, 40'd0, 12'd0, 12'd4095));
        plan_typed(40'd12288, make_gather(40'h00_0300_0000, 40'd3, 12'd0, 12'd0));
        plan_typed(40'hFF_FFFF_FFFF,
                   make_gather(40'hFF_FF00_0FFF, 40'h00_0FFF_FFFF, 12'd0, 12'd4095));
        // small upscale, round half up
        plan_write(nnra_pkg::REG_CORNER_ALIGN, 32'hFFFF_FFFF);
        plan_write(nnra_pkg::REG_IN_ROWS,   32'd3);
        plan_write(nnra_pkg::REG_IN_COLS,   32'd4);
        plan_write(nnra_pkg::REG_OUT_ROWS,  32'd5);
        plan_write(nnra_pkg::REG_OUT_COLS,  32'd7);
        plan_write(nnra_pkg::REG_ROW_RATIO, 32'h0000_999A);
        plan_write(nnra_pkg::REG_COL_RATIO, 32'h0000_8000);
        plan_item(40'd1);
        plan_item(40'd2);
        plan_item(40'd3);
        plan_item(40'd6);
        plan_item(40'd34);
        plan_item(40'd35);
        // same sizes, floor
        plan_write(nnra_pkg::REG_CORNER_ALIGN, 32'hFFFF_FFFE);
        plan_item(40'd1);
        plan_item(40'd3);
        plan_item(40'd34);
        // write to a register that does not exist
        plan_write(UNUSED_REG, 32'hFFFF_FFFF);
        plan_item(40'd34);
        plan_write(nnra_pkg::REG_ROW_RATIO, 32'd0);
        plan_item(40'd20);

        repeat (8) @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (plan[i])
        begin
            if (plan[i].is_write)
            begin
                s_tvalid <= 1'b0;
                drain();
                write_register(plan[i].reg_idx, plan[i].wdata);
            end
            else
            begin
                send_item(plan[i].index, plan[i].typed, plan[i].want);
                item_gap();
            end
        end
        s_tvalid <= 1'b0;
        drain();

        for (int phase = 0; phase < PHASES; phase++)
        begin
            quiet = (phase == PHASES - 1);
            randomize_registers();
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                send_item(pick_index(), 1'b0, '0);
                item_gap();
            end
            s_tvalid <= 1'b0;
            drain();
        end

        repeat (100) @(negedge clk);
        if (pending_gathers.size() != 0)
        begin
            $error("%0d result items never arrived", pending_gathers.size());
            mismatch_count++;
        end
        if (mismatch_count == 0)
            $display("[nearest_neighbor_resize_address] OK");
        else
            $display("[nearest_neighbor_resize_address] ERROR");
        $finish;
    end

endmodule

@@ files.f @@
rtl/core/nnra_pkg.sv
rtl/core/nnra_divider.sv
rtl/core/nnra_map.sv
rtl/core/nearest_neighbor_resize_address.sv
sim/nearest_neighbor_resize_address_tb.sv
